// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on a clock with an active-low asynchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/dbt_pkg.sv
// ----------------------------------------------------------------------------
// dbt_pkg
// shared types and constants of the debounced relay toggle block
// ----------------------------------------------------------------------------
package dbt_pkg;

	localparam int CHANNEL_COUNT_DEF = 8;
	localparam int TIME_WIDTH_DEF    = 32;

	localparam int DELAY_W  = 16;
	localparam int BTN_W    = 8;
	localparam int NOW_W    = 32;
	localparam int IDX_W    = 3;
	localparam int CMD_W    = 2;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_SET     = 2'd1,
		CMD_RESTORE = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_e_t;

	// accepted item as seen by the relay merge stage
	typedef struct packed {
		logic             fire;
		cmd_e_t           cmd;
		logic [IDX_W-1:0] relay_index;
		logic             relay_value;
		logic [BTN_W-1:0] restore_bits;
	} ctrl_t;

endpackage

// File: rtl/dbt_lane.sv
// ----------------------------------------------------------------------------
// dbt_lane
// one debounce channel: raw edge timestamp, settle compare, stable level
// ----------------------------------------------------------------------------
module dbt_lane #(
	parameter int TIME_WIDTH = dbt_pkg::TIME_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_en,
	input  logic                        raw_bit,
	input  logic [TIME_WIDTH-1:0]       now,
	input  logic [dbt_pkg::DELAY_W-1:0] delay,
	output logic                        stable,
	output logic                        rise
);

	localparam int CMP_W = (TIME_WIDTH > dbt_pkg::DELAY_W) ? TIME_WIDTH : dbt_pkg::DELAY_W;

	logic                  prev_q;
	logic                  deb_q;
	logic [TIME_WIDTH-1:0] stamp_q;

	logic [TIME_WIDTH-1:0] stamp_d;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  settled;
	logic                  deb_d;

	always_comb begin
		stamp_d = (raw_bit != prev_q) ? now : stamp_q;
		// wraps modulo 2^TIME_WIDTH
		elapsed = now - stamp_d;
		settled = CMP_W'(elapsed) > CMP_W'(delay);
		deb_d   = settled ? raw_bit : deb_q;
		rise    = settled & raw_bit & ~deb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			deb_q   <= 1'b0;
			stamp_q <= '0;
		end else if (sample_en) begin
			prev_q  <= raw_bit;
			deb_q   <= deb_d;
			stamp_q <= stamp_d;
		end
	end

	assign stable = deb_q;

endmodule

// File: rtl/dbt_merge.sv
// ----------------------------------------------------------------------------
// dbt_merge
// relay update from the lanes' rising edges or a set/restore command, store tracking, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbt_merge #(
	parameter int CHANNEL_COUNT = dbt_pkg::CHANNEL_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dbt_pkg::ctrl_t           ctrl,
	input  logic [CHANNEL_COUNT-1:0] rise_mask,
	input  logic                     m_tready,
	output logic                     out_valid,
	output logic                     in_ready,
	output logic [CHANNEL_COUNT-1:0] relay,
	output logic [CHANNEL_COUNT-1:0] toggled,
	output logic                     store
);

	logic [CHANNEL_COUNT-1:0] relay_q;
	logic [CHANNEL_COUNT-1:0] stored_q;
	logic [CHANNEL_COUNT-1:0] tog_q;
	logic                     store_q;
	logic                     valid_q;

	logic [CHANNEL_COUNT-1:0] relay_d;
	logic [CHANNEL_COUNT-1:0] stored_d;
	logic [CHANNEL_COUNT-1:0] tog_d;
	logic                     store_d;
	logic [CHANNEL_COUNT-1:0] set_mask;

	logic                     non_sample_fire;
	logic                     copy_fire;

	always_comb begin
		relay_d  = relay_q;
		stored_d = stored_q;
		tog_d    = '0;
		store_d  = 1'b0;
		set_mask = '0;
		if (32'(ctrl.relay_index) < CHANNEL_COUNT) begin
			set_mask = CHANNEL_COUNT'(1) << ctrl.relay_index;
		end
		case (ctrl.cmd)
			dbt_pkg::CMD_SAMPLE: begin
				relay_d  = relay_q ^ rise_mask;
				tog_d    = rise_mask;
				store_d  = (relay_d != stored_q);
				stored_d = relay_d;
			end
			dbt_pkg::CMD_SET: begin
				relay_d = ctrl.relay_value ? (relay_q | set_mask) : (relay_q & ~set_mask);
			end
			dbt_pkg::CMD_RESTORE: begin
				relay_d  = CHANNEL_COUNT'(ctrl.restore_bits);
				stored_d = relay_d;
			end
			dbt_pkg::CMD_NOP: begin
				relay_d = relay_q;
			end
			default: begin
				relay_d = relay_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q  <= '0;
			stored_q <= '0;
			tog_q    <= '0;
			store_q  <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ctrl.fire) begin
				relay_q  <= relay_d;
				stored_q <= stored_d;
				tog_q    <= tog_d;
				store_q  <= store_d;
				valid_q  <= 1'b1;
			end else if (m_tready) begin
				valid_q  <= 1'b0;
			end
		end
	end

	// a new item goes in when the result slot is empty or drains this cycle
	assign in_ready  = ~valid_q | m_tready;
	assign out_valid = valid_q;
	assign relay     = relay_q;
	assign toggled   = tog_q;
	assign store     = store_q;

	assign non_sample_fire = ctrl.fire && (ctrl.cmd != dbt_pkg::CMD_SAMPLE);
	assign copy_fire       = ctrl.fire && ((ctrl.cmd == dbt_pkg::CMD_SAMPLE) ||
		(ctrl.cmd == dbt_pkg::CMD_RESTORE));

	`ASSERT_NEXT(a_result_follows, clk, arst_n, ctrl.fire, valid_q)
	`ASSERT_NEXT(a_no_toggle_off_sample, clk, arst_n, non_sample_fire, (tog_q == '0) && !store_q)
	`ASSERT_NEXT(a_copy_tracks_relay, clk, arst_n, copy_fire, stored_q == relay_q)

endmodule

// File: rtl/debounced_button_relay_toggle.sv
// ----------------------------------------------------------------------------
// debounced_button_relay_toggle
// debounced push-button bank that toggles a relay bit per button
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ stream: s_tuser carries the command (sample, set
//   one relay, restore), s_tdata the buttons, the millisecond time and the
//   set/restore arguments. Every item gives one result on the m_ stream with
//   the relay bits, debounced buttons, toggled mask and a store request.
//   cfg_valid/cfg_data write the debounce delay in ms; cfg_ready is always
//   high and writes are meant to happen while no item is in flight.
//   m_tvalid rises in the cycle after the input transfer. Throughput is one
//   item per cycle while results are taken: all channel lanes compare their
//   timestamps in parallel and the relay merge closes in the same cycle.
//   Reset clears all debounce state, relays and the stored copy, and loads
//   the delay with 50 ms.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken; a transfer on both sides in the same
//   cycle keeps one item per cycle flowing.
// ----------------------------------------------------------------------------
module debounced_button_relay_toggle #(
	parameter int CHANNEL_COUNT = dbt_pkg::CHANNEL_COUNT_DEF,
	parameter int TIME_WIDTH    = dbt_pkg::TIME_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// raw_buttons[7:0], now_ms[39:8], relay_index[42:40], relay_value[43],
	// restore_bits[51:44], zero pad
	input  logic [dbt_pkg::S_TDATA_W-1:0] s_tdata,
	// command[1:0]
	input  logic [dbt_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// relay_bits[7:0], stable_buttons[15:8], toggled_mask[23:16],
	// store_request[24], zero pad
	output logic [dbt_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dbt_pkg::DELAY_W-1:0]   cfg_data
);

	logic [dbt_pkg::DELAY_W-1:0] delay_q;

	logic [dbt_pkg::BTN_W-1:0] raw_buttons;
	logic [dbt_pkg::NOW_W-1:0] now_ms;
	logic [CHANNEL_COUNT-1:0]  raw_ch;
	logic [TIME_WIDTH-1:0]     now_tw;
	logic                      fire;
	logic                      sample_en;
	dbt_pkg::ctrl_t            ctrl;

	logic [CHANNEL_COUNT-1:0] stable;
	logic [CHANNEL_COUNT-1:0] rise_mask;
	logic [CHANNEL_COUNT-1:0] relay;
	logic [CHANNEL_COUNT-1:0] toggled;
	logic                     store;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= dbt_pkg::DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delay_q <= cfg_data;
		end
	end

	assign raw_buttons = s_tdata[7:0];
	assign now_ms      = s_tdata[39:8];
	assign raw_ch      = CHANNEL_COUNT'(raw_buttons);
	assign now_tw      = TIME_WIDTH'(now_ms);

	assign fire      = s_tvalid & s_tready;
	assign sample_en = fire && (dbt_pkg::cmd_e_t'(s_tuser) == dbt_pkg::CMD_SAMPLE);

	always_comb begin
		ctrl.fire         = fire;
		ctrl.cmd          = dbt_pkg::cmd_e_t'(s_tuser);
		ctrl.relay_index  = s_tdata[42:40];
		ctrl.relay_value  = s_tdata[43];
		ctrl.restore_bits = s_tdata[51:44];
	end

	for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_lane
		dbt_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.sample_en (sample_en),
			.raw_bit   (raw_ch[i]),
			.now       (now_tw),
			.delay     (delay_q),
			.stable    (stable[i]),
			.rise      (rise_mask[i])
		);
	end

	dbt_merge #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.rise_mask (rise_mask),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.in_ready  (s_tready),
		.relay     (relay),
		.toggled   (toggled),
		.store     (store)
	);

	assign m_tdata = {7'd0, store, 8'(toggled), 8'(stable), 8'(relay)};

endmodule
